FILE: hdl/trbm_pkg.sv
// Shared constants, types and helpers for the trace ring buffer merged readout block.
package trbm_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int RING_DEPTH  = 1024;

    localparam int SRC_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int PTR_W     = $clog2(RING_DEPTH);
    localparam int ADDR_W    = SRC_W + PTR_W;
    localparam int MEM_DEPTH = NUM_SOURCES * (2 ** PTR_W);

    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_FREEZE = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;
    localparam logic [1:0] OP_NEXT   = 2'd3;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef struct packed {
        logic rec_write;
        logic set_frozen;
        logic begin_init;
        logic nx_clear;
        logic max_step;
        logic skip_step;
        logic nx_step;
        logic rd_best;
        logic pay_load;
        logic delta_load;
        logic hdr_load;
        logic end_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic ridx_last;
        logic skip_more;
        logic found;
        logic out_free;
        logic frozen;
    } status_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

FILE: hdl/trbm_ctrl.sv
// Controller state machine: sequences record, freeze, start scan and merge steps.
module trbm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  trbm_pkg::status_t     status,
    output trbm_pkg::cmd_t        cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_BEGIN    = 4'd1;
    localparam logic [3:0] S_MAX_RD   = 4'd2;
    localparam logic [3:0] S_MAX_CMP  = 4'd3;
    localparam logic [3:0] S_SKIP_RD  = 4'd4;
    localparam logic [3:0] S_SKIP_CMP = 4'd5;
    localparam logic [3:0] S_HDR      = 4'd6;
    localparam logic [3:0] S_NX_RD    = 4'd7;
    localparam logic [3:0] S_NX_CMP   = 4'd8;
    localparam logic [3:0] S_NX_DEC   = 4'd9;
    localparam logic [3:0] S_PAY_RD   = 4'd10;
    localparam logic [3:0] S_PAY      = 4'd11;
    localparam logic [3:0] S_DELTA    = 4'd12;
    localparam logic [3:0] S_END      = 4'd13;
    localparam logic [3:0] S_OUT      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        trbm_pkg::OP_RECORD: cmd.rec_write  = 1'b1;
                        trbm_pkg::OP_FREEZE: cmd.set_frozen = 1'b1;
                        trbm_pkg::OP_START:  state_next     = S_BEGIN;
                        trbm_pkg::OP_NEXT:
                        begin
                            cmd.nx_clear = 1'b1;
                            state_next   = S_NX_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_BEGIN:
            begin
                cmd.begin_init = 1'b1;
                state_next     = S_MAX_RD;
            end
            S_MAX_RD: state_next = S_MAX_CMP;
            S_MAX_CMP:
            begin
                cmd.max_step = 1'b1;
                state_next   = status.ridx_last ? S_SKIP_RD : S_MAX_RD;
            end
            S_SKIP_RD: state_next = S_SKIP_CMP;
            S_SKIP_CMP:
            begin
                cmd.skip_step = 1'b1;
                if (!status.skip_more && status.ridx_last)
                    state_next = S_HDR;
                else
                    state_next = S_SKIP_RD;
            end
            S_HDR:
            begin
                cmd.hdr_load = 1'b1;
                state_next   = S_OUT;
            end
            S_NX_RD: state_next = S_NX_CMP;
            S_NX_CMP:
            begin
                cmd.nx_step = 1'b1;
                state_next  = status.ridx_last ? S_NX_DEC : S_NX_RD;
            end
            S_NX_DEC: state_next = status.found ? S_PAY_RD : S_END;
            S_PAY_RD:
            begin
                cmd.rd_best = 1'b1;
                state_next  = S_PAY;
            end
            S_PAY:
            begin
                cmd.rd_best  = 1'b1;
                cmd.pay_load = 1'b1;
                state_next   = S_DELTA;
            end
            S_DELTA:
            begin
                cmd.delta_load = 1'b1;
                state_next     = S_OUT;
            end
            S_END:
            begin
                cmd.end_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hdl/trbm_dp.sv
// Datapath: ring memories, pointers, start-time scan, merge compare and output register.
module trbm_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  trbm_pkg::cmd_t        cmd,
    output trbm_pkg::status_t     status,
    input  logic [1:0]            buffer_select,
    input  logic [63:0]           timestamp,
    input  logic [15:0]           event_id,
    input  logic [31:0]           arg0,
    input  logic [31:0]           arg1,
    input  logic [31:0]           arg2,
    input  logic [31:0]           arg3,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [1:0]            result_kind,
    output logic [1:0]            source_id,
    output logic [63:0]           time_offset,
    output logic [63:0]           time_delta,
    output logic [15:0]           out_event_id,
    output logic [31:0]           out_arg0,
    output logic [31:0]           out_arg1,
    output logic [31:0]           out_arg2,
    output logic [31:0]           out_arg3
);

    localparam int SW = trbm_pkg::SRC_W;
    localparam int PW = trbm_pkg::PTR_W;
    localparam int NS = trbm_pkg::NUM_SOURCES;

    logic [63:0]  stamp_mem [trbm_pkg::MEM_DEPTH];
    logic [15:0]  event_mem [trbm_pkg::MEM_DEPTH];
    logic [63:0]  argl_mem  [trbm_pkg::MEM_DEPTH];
    logic [63:0]  argh_mem  [trbm_pkg::MEM_DEPTH];

    logic [PW-1:0] wp_reg [NS];
    logic [PW-1:0] rp_reg [NS];
    logic [NS-1:0] wrap_reg;
    logic          frozen_reg;
    logic [63:0]   first_time_reg;
    logic [63:0]   last_offset_reg;
    logic [63:0]   start_reg;
    logic [SW-1:0] ridx_reg;
    logic [SW-1:0] best_reg;
    logic [63:0]   best_time_reg;
    logic          found_reg;

    logic [63:0]   rd_stamp_reg;
    logic [15:0]   rd_event_reg;
    logic [63:0]   rd_argl_reg;
    logic [63:0]   rd_argh_reg;

    logic [1:0]    res_kind_reg;
    logic [SW-1:0] res_src_reg;
    logic [63:0]   res_offset_reg;
    logic [63:0]   res_delta_reg;
    logic [15:0]   res_event_reg;
    logic [63:0]   res_argl_reg;
    logic [63:0]   res_argh_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [SW-1:0] out_src_reg;
    logic [63:0]   out_offset_reg;
    logic [63:0]   out_delta_reg;
    logic [15:0]   out_event_reg;
    logic [63:0]   out_argl_reg;
    logic [63:0]   out_argh_reg;

    logic [SW-1:0]     wsel;
    logic              wr_en;
    logic [SW-1:0]     sel;
    logic [PW-1:0]     sel_rp;
    logic [PW-1:0]     sel_wp;
    logic              sel_valid;
    logic              ridx_last;
    logic [SW-1:0]     ridx_step;
    logic              skip_more;
    logic              cand;
    logic [trbm_pkg::ADDR_W-1:0] rd_addr;
    logic [trbm_pkg::ADDR_W-1:0] wr_addr;

    assign wsel  = SW'(buffer_select);
    assign wr_en = cmd.rec_write && !frozen_reg && (32'(buffer_select) < NS);
    assign wr_addr = {wsel, wp_reg[wsel]};

    assign sel       = cmd.rd_best ? best_reg : ridx_reg;
    assign sel_rp    = rp_reg[sel];
    assign sel_wp    = wp_reg[sel];
    // Entries fill in order from zero, so a slot holds data once the ring
    // has wrapped or the slot lies below the write pointer.
    assign sel_valid = wrap_reg[sel] || (sel_rp < sel_wp);
    assign rd_addr   = {sel, sel_rp};

    assign ridx_last = (ridx_reg == SW'(NS - 1));
    assign ridx_step = ridx_last ? '0 : ridx_reg + 1'b1;
    assign skip_more = sel_valid && (rd_stamp_reg < start_reg) && (sel_rp != sel_wp);
    assign cand      = (sel_rp != sel_wp) && sel_valid &&
                       (!found_reg || (rd_stamp_reg < best_time_reg));

    assign status.ridx_last = ridx_last;
    assign status.skip_more = skip_more;
    assign status.found     = found_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.frozen    = frozen_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr] <= timestamp;
            event_mem[wr_addr] <= event_id;
            argl_mem[wr_addr]  <= {arg1, arg0};
            argh_mem[wr_addr]  <= {arg3, arg2};
        end
        rd_stamp_reg <= stamp_mem[rd_addr];
        rd_event_reg <= event_mem[rd_addr];
        rd_argl_reg  <= argl_mem[rd_addr];
        rd_argh_reg  <= argh_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NS; r++)
            begin
                wp_reg[r] <= '0;
                rp_reg[r] <= '0;
            end
            wrap_reg        <= '0;
            frozen_reg      <= 1'b0;
            first_time_reg  <= '0;
            last_offset_reg <= '0;
            start_reg       <= '0;
            ridx_reg        <= '0;
            best_reg        <= '0;
            best_time_reg   <= '0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg[wsel] <= trbm_pkg::next_ptr(wp_reg[wsel]);
                if (wp_reg[wsel] == PW'(trbm_pkg::RING_DEPTH - 1))
                    wrap_reg[wsel] <= 1'b1;
            end
            if (cmd.set_frozen)
                frozen_reg <= 1'b1;
            if (cmd.begin_init)
            begin
                frozen_reg <= 1'b1;
                start_reg  <= '0;
                ridx_reg   <= '0;
                for (int r = 0; r < NS; r++)
                begin
                    if (wrap_reg[r] || (trbm_pkg::next_ptr(wp_reg[r]) < wp_reg[r]))
                        rp_reg[r] <= trbm_pkg::next_ptr(wp_reg[r]);
                    else
                        rp_reg[r] <= '0;
                end
            end
            if (cmd.max_step)
            begin
                if (sel_valid && (rd_stamp_reg > start_reg))
                    start_reg <= rd_stamp_reg;
                ridx_reg <= ridx_step;
            end
            if (cmd.skip_step)
            begin
                if (skip_more)
                    rp_reg[sel] <= trbm_pkg::next_ptr(sel_rp);
                else
                    ridx_reg <= ridx_step;
            end
            if (cmd.hdr_load)
            begin
                first_time_reg  <= start_reg;
                last_offset_reg <= '0;
            end
            if (cmd.nx_clear)
            begin
                found_reg <= 1'b0;
                ridx_reg  <= '0;
            end
            if (cmd.nx_step)
            begin
                if (cand)
                begin
                    found_reg     <= 1'b1;
                    best_reg      <= ridx_reg;
                    best_time_reg <= rd_stamp_reg;
                end
                ridx_reg <= ridx_step;
            end
            if (cmd.pay_load)
                rp_reg[sel] <= trbm_pkg::next_ptr(sel_rp);
            if (cmd.delta_load)
                last_offset_reg <= res_offset_reg;
            if (cmd.end_load)
                frozen_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_load)
        begin
            res_kind_reg   <= trbm_pkg::KIND_HEADER;
            res_src_reg    <= '0;
            res_offset_reg <= start_reg;
            res_delta_reg  <= '0;
            res_event_reg  <= '0;
            res_argl_reg   <= '0;
            res_argh_reg   <= '0;
        end
        if (cmd.end_load)
        begin
            res_kind_reg   <= trbm_pkg::KIND_END;
            res_src_reg    <= '0;
            res_offset_reg <= '0;
            res_delta_reg  <= '0;
            res_event_reg  <= '0;
            res_argl_reg   <= '0;
            res_argh_reg   <= '0;
        end
        if (cmd.pay_load)
        begin
            res_kind_reg   <= trbm_pkg::KIND_EVENT;
            res_src_reg    <= best_reg;
            res_offset_reg <= rd_stamp_reg - first_time_reg;
            res_event_reg  <= rd_event_reg;
            res_argl_reg   <= rd_argl_reg;
            res_argh_reg   <= rd_argh_reg;
        end
        if (cmd.delta_load)
            res_delta_reg <= res_offset_reg - last_offset_reg;
        if (cmd.out_load)
        begin
            out_kind_reg   <= res_kind_reg;
            out_src_reg    <= res_src_reg;
            out_offset_reg <= res_offset_reg;
            out_delta_reg  <= res_delta_reg;
            out_event_reg  <= res_event_reg;
            out_argl_reg   <= res_argl_reg;
            out_argh_reg   <= res_argh_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign source_id    = 2'(out_src_reg);
    assign time_offset  = out_offset_reg;
    assign time_delta   = out_delta_reg;
    assign out_event_id = out_event_reg;
    assign out_arg0     = out_argl_reg[31:0];
    assign out_arg1     = out_argl_reg[63:32];
    assign out_arg2     = out_argh_reg[31:0];
    assign out_arg3     = out_argh_reg[63:32];

endmodule

FILE: hdl/trace_ring_buffers_merged_readout.sv
// Top level of the multi-source trace ring buffer with merged readout.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_ready  opcode, buffer_select, timestamp, event_id, arg0..3
//  out       source     out_valid/out_ready  result_kind, source_id, time_offset, time_delta,
//                                            out_event_id, out_arg0..3
//
// Record and freeze: no result. Start readout: header result after a scan of the ring heads,
// plus one read and one compare per skipped entry, at most RING_DEPTH - 1 per ring.
// Read next: an event result, or an end result when no ring holds an unread entry; one read
// and one compare per ring head through the single shared memory read port.
// Reset clears pointers and per-ring fill state, which stands in for the valid bits; the ring
// memories need no clearing. A result waiting on out_ready holds the controller.
module trace_ring_buffers_merged_readout (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [1:0]  buffer_select,
    input  logic [63:0] timestamp,
    input  logic [15:0] event_id,
    input  logic [31:0] arg0,
    input  logic [31:0] arg1,
    input  logic [31:0] arg2,
    input  logic [31:0] arg3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [1:0]  source_id,
    output logic [63:0] time_offset,
    output logic [63:0] time_delta,
    output logic [15:0] out_event_id,
    output logic [31:0] out_arg0,
    output logic [31:0] out_arg1,
    output logic [31:0] out_arg2,
    output logic [31:0] out_arg3
);

    trbm_pkg::cmd_t    cmd;
    trbm_pkg::status_t status;

    // Sequence each transaction; hold the state machine while the output is busy.
    trbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    // Store events, scan ring heads and build the result.
    trbm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .buffer_select (buffer_select),
        .timestamp     (timestamp),
        .event_id      (event_id),
        .arg0          (arg0),
        .arg1          (arg1),
        .arg2          (arg2),
        .arg3          (arg3),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .result_kind   (result_kind),
        .source_id     (source_id),
        .time_offset   (time_offset),
        .time_delta    (time_delta),
        .out_event_id  (out_event_id),
        .out_arg0      (out_arg0),
        .out_arg1      (out_arg1),
        .out_arg2      (out_arg2),
        .out_arg3      (out_arg3)
    );

`ifndef ASSERT_OFF
    a_freeze_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == trbm_pkg::OP_FREEZE) |=> status.frozen)
        else $error("freeze transaction did not set frozen");

    a_start_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == trbm_pkg::OP_START) |=> ##1 status.frozen)
        else $error("start transaction did not freeze the rings");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("output register overwritten before transaction completed");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pay_load |-> !in_ready)
        else $error("input taken while merge step in progress");
`endif

endmodule

FILE: verif/trace_ring_buffers_merged_readout_tb.sv
// Self-checking testbench for the trace ring buffer merged readout block.
`timescale 1ns / 100ps

module trace_ring_buffers_merged_readout_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [1:0]  buffer_select;
    logic [63:0] timestamp;
    logic [15:0] event_id;
    logic [31:0] arg0, arg1, arg2, arg3;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [1:0]  source_id;
    logic [63:0] time_offset;
    logic [63:0] time_delta;
    logic [15:0] out_event_id;
    logic [31:0] out_arg0, out_arg1, out_arg2, out_arg3;

    trace_ring_buffers_merged_readout DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .buffer_select(buffer_select), .timestamp(timestamp),
        .event_id(event_id), .arg0(arg0), .arg1(arg1), .arg2(arg2), .arg3(arg3),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .source_id(source_id), .time_offset(time_offset),
        .time_delta(time_delta), .out_event_id(out_event_id),
        .out_arg0(out_arg0), .out_arg1(out_arg1), .out_arg2(out_arg2), .out_arg3(out_arg3)
    );

    // One expected readout result
    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  src;
        logic [63:0] offset;
        logic [63:0] delta;
        logic [15:0] id;
        logic [31:0] a [4];
    } readout_t;

    readout_t readout_q [$];
    int       error_count = 0;

    // Shadow copy of the trace rings
    logic [63:0] ring_stamp [trbm_pkg::NUM_SOURCES][trbm_pkg::RING_DEPTH];
    logic [15:0] ring_event [trbm_pkg::NUM_SOURCES][trbm_pkg::RING_DEPTH];
    logic [31:0] ring_args  [trbm_pkg::NUM_SOURCES][trbm_pkg::RING_DEPTH][4];
    bit          ring_valid [trbm_pkg::NUM_SOURCES][trbm_pkg::RING_DEPTH];
    logic [trbm_pkg::PTR_W-1:0] wr_ptr [trbm_pkg::NUM_SOURCES];
    logic [trbm_pkg::PTR_W-1:0] rd_ptr [trbm_pkg::NUM_SOURCES];
    bit          frozen;
    logic [63:0] model_start;
    logic [63:0] prev_offset;
    logic [1:0]  last_kind;
    logic [63:0] stamp_clock;

    function automatic logic [trbm_pkg::PTR_W-1:0] advance(
        input logic [trbm_pkg::PTR_W-1:0] p);
        return (p == trbm_pkg::PTR_W'(trbm_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Update the shadow rings for one transaction and queue any result it causes
    function automatic void model_transaction(input logic [1:0] op, input logic [1:0] sel,
                                              input logic [63:0] ts, input logic [15:0] id,
                                              input logic [31:0] a [4]);
        readout_t   res;
        logic [63:0] st;
        bit          found;
        int          best;
        logic [63:0] best_ts;
        logic [trbm_pkg::PTR_W-1:0] oldest;
        res.kind = trbm_pkg::KIND_HEADER;
        res.src = '0;
        res.offset = '0;
        res.delta = '0;
        res.id = '0;
        for (int j = 0; j < 4; j++)
            res.a[j] = '0;
        case (op)
            trbm_pkg::OP_RECORD:
            begin
                if (frozen || sel >= trbm_pkg::NUM_SOURCES)
                    return;
                ring_stamp[sel][wr_ptr[sel]] = ts;
                ring_event[sel][wr_ptr[sel]] = id;
                for (int j = 0; j < 4; j++)
                    ring_args[sel][wr_ptr[sel]][j] = a[j];
                ring_valid[sel][wr_ptr[sel]] = 1'b1;
                wr_ptr[sel] = advance(wr_ptr[sel]);
                return;
            end
            trbm_pkg::OP_FREEZE:
            begin
                frozen = 1'b1;
                return;
            end
            trbm_pkg::OP_START:
            begin
                frozen = 1'b1;
                st = '0;
                for (int r = 0; r < trbm_pkg::NUM_SOURCES; r++)
                begin
                    oldest = advance(wr_ptr[r]);
                    rd_ptr[r] = ring_valid[r][oldest] ? oldest : '0;
                end
                for (int r = 0; r < trbm_pkg::NUM_SOURCES; r++)
                    if (ring_valid[r][rd_ptr[r]] && ring_stamp[r][rd_ptr[r]] > st)
                        st = ring_stamp[r][rd_ptr[r]];
                // Skip entries older than the start time
                for (int r = 0; r < trbm_pkg::NUM_SOURCES; r++)
                    for (int g = 0; g < trbm_pkg::RING_DEPTH; g++)
                    begin
                        if (!ring_valid[r][rd_ptr[r]] || ring_stamp[r][rd_ptr[r]] >= st ||
                            rd_ptr[r] == wr_ptr[r])
                            break;
                        rd_ptr[r] = advance(rd_ptr[r]);
                    end
                model_start = st;
                prev_offset = '0;
                res.offset = st;
            end
            default:
            begin
                found = 1'b0;
                best = 0;
                best_ts = '0;
                for (int r = 0; r < trbm_pkg::NUM_SOURCES; r++)
                    if (rd_ptr[r] != wr_ptr[r] && ring_valid[r][rd_ptr[r]] &&
                        (!found || ring_stamp[r][rd_ptr[r]] < best_ts))
                    begin
                        found = 1'b1;
                        best = r;
                        best_ts = ring_stamp[r][rd_ptr[r]];
                    end
                if (!found)
                begin
                    res.kind = trbm_pkg::KIND_END;
                    frozen = 1'b0;
                end
                else
                begin
                    res.kind = trbm_pkg::KIND_EVENT;
                    res.src = 2'(best);
                    res.offset = best_ts - model_start;
                    res.delta = res.offset - prev_offset;
                    res.id = ring_event[best][rd_ptr[best]];
                    for (int j = 0; j < 4; j++)
                        res.a[j] = ring_args[best][rd_ptr[best]][j];
                    prev_offset = res.offset;
                    rd_ptr[best] = advance(rd_ptr[best]);
                end
            end
        endcase
        last_kind = res.kind;
        readout_q.insert(readout_q.size(), res);
    endfunction

    // Drive one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic [1:0] op, input logic [1:0] sel,
                             input logic [63:0] ts, input logic [15:0] id,
                             input logic [31:0] a0, input logic [31:0] a1,
                             input logic [31:0] a2, input logic [31:0] a3);
        int          gap;
        logic [31:0] a [4];
        gap = int'($urandom_range(0, 10));
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        buffer_select <= sel;
        timestamp <= ts;
        event_id <= id;
        arg0 <= a0;
        arg1 <= a1;
        arg2 <= a2;
        arg3 <= a3;
        do
            @(posedge clk);
        while (!in_ready);
        a[0] = a0;
        a[1] = a1;
        a[2] = a2;
        a[3] = a3;
        model_transaction(op, sel, ts, id, a);
    endtask

    task automatic record_event(input logic [1:0] sel, input logic [63:0] ts);
        send_item(trbm_pkg::OP_RECORD, sel, ts, 16'($urandom), $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic send_op(input logic [1:0] op);
        send_item(op, 2'($urandom), {$urandom, $urandom}, 16'($urandom),
                  $urandom, $urandom, $urandom, $urandom);
    endtask

    // Start a readout and drain it until end is reported
    task automatic drain_readout();
        send_op(trbm_pkg::OP_START);
        do
            send_op(trbm_pkg::OP_NEXT);
        while (last_kind != trbm_pkg::KIND_END);
    endtask

    task automatic test_read_without_start();
        send_op(trbm_pkg::OP_NEXT);
        send_op(trbm_pkg::OP_NEXT);
    endtask

    task automatic test_field_extremes();
        send_item(trbm_pkg::OP_RECORD, 2'd0, 64'd0, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(trbm_pkg::OP_RECORD, 2'd3, '1, 16'hFFFF, '1, '1, '1, '1);
        send_item(trbm_pkg::OP_RECORD, 2'd1, 64'd5, 16'h5A5A, 32'hA5A5A5A5, 32'h5A5A5A5A,
                  32'hFFFF0000, 32'h0000FFFF);
        drain_readout();
        send_op(trbm_pkg::OP_NEXT);
    endtask

    task automatic test_freeze_drops_records();
        record_event(2'd2, 64'd100);
        send_op(trbm_pkg::OP_FREEZE);
        record_event(2'd0, 64'd101);
        record_event(2'd2, 64'd102);
        drain_readout();
    endtask

    task automatic test_equal_stamps();
        for (int r = trbm_pkg::NUM_SOURCES - 1; r >= 0; r--)
            record_event(2'(r), 64'd500);
        record_event(2'd1, 64'd500);
        drain_readout();
    endtask

    task automatic test_out_of_order_stamps();
        record_event(2'd0, 64'd900);
        record_event(2'd0, 64'd10);
        record_event(2'd1, 64'd950);
        record_event(2'd1, 64'd3);
        drain_readout();
    endtask

    // Overfill one ring so it wraps, and let a late start time skip most of it
    task automatic test_wrap_and_skip();
        for (int i = 0; i < trbm_pkg::RING_DEPTH + 6; i++)
            record_event(2'd1, 64'd2000 + 64'(i));
        record_event(2'd3, 64'd2000 + 64'(trbm_pkg::RING_DEPTH - 20));
        drain_readout();
        stamp_clock = 64'd2000 + 64'(trbm_pkg::RING_DEPTH + 10);
    endtask

    // Mostly well-formed record/readout sessions, with some noise mixed in
    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = int'($urandom_range(1, 12));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_op(2'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 15) == 0)
                        stamp_clock = {$urandom, $urandom};
                    else if ($urandom_range(0, 4) != 0)
                        stamp_clock = stamp_clock + 64'($urandom_range(0, 40));
                    record_event(2'($urandom), stamp_clock);
                end
                sent++;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                send_op(trbm_pkg::OP_FREEZE);
                sent++;
            end
            send_op(trbm_pkg::OP_START);
            sent++;
            do
            begin
                send_op(trbm_pkg::OP_NEXT);
                sent++;
            end
            while (last_kind != trbm_pkg::KIND_END);
            if ($urandom_range(0, 2) == 0)
            begin
                send_op(trbm_pkg::OP_NEXT);
                sent++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Result side: random stalls, then compare each transaction with the oldest expectation
    initial
    begin
        readout_t exp_r;
        int       stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = int'($urandom_range(0, 10));
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (readout_q.size() == 0)
            begin
                $error("unexpected result: kind %0d", result_kind);
                error_count++;
            end
            else
            begin
                exp_r = readout_q.pop_front();
                check_field("result_kind", 64'(exp_r.kind), 64'(result_kind));
                check_field("source_id", 64'(exp_r.src), 64'(source_id));
                check_field("time_offset", exp_r.offset, time_offset);
                check_field("time_delta", exp_r.delta, time_delta);
                check_field("out_event_id", 64'(exp_r.id), 64'(out_event_id));
                check_field("out_arg0", 64'(exp_r.a[0]), 64'(out_arg0));
                check_field("out_arg1", 64'(exp_r.a[1]), 64'(out_arg1));
                check_field("out_arg2", 64'(exp_r.a[2]), 64'(out_arg2));
                check_field("out_arg3", 64'(exp_r.a[3]), 64'(out_arg3));
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = trbm_pkg::OP_RECORD;
        buffer_select = '0;
        timestamp = '0;
        event_id = '0;
        {arg0, arg1, arg2, arg3} = '0;
        for (int r = 0; r < trbm_pkg::NUM_SOURCES; r++)
        begin
            wr_ptr[r] = '0;
            rd_ptr[r] = '0;
            for (int i = 0; i < trbm_pkg::RING_DEPTH; i++)
                ring_valid[r][i] = 1'b0;
        end
        frozen = 1'b0;
        model_start = '0;
        prev_offset = '0;
        last_kind = trbm_pkg::KIND_HEADER;
        stamp_clock = 64'd100000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_without_start();
        test_field_extremes();
        test_freeze_drops_records();
        test_equal_stamps();
        test_out_of_order_stamps();
        test_wrap_and_skip();
        test_random(780);

        in_valid <= 1'b0;
        while (readout_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #60ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
